// ===== src/mols_pkg.sv =====
package mols_pkg;

  // Field widths of the beats on both channels.
  localparam int unsigned GradeW  = 16;
  localparam int unsigned MedianW = 17;
  localparam int unsigned StatusW = 2;

  // Bit index over a grade, used by the bitwise selection passes.
  localparam int unsigned BitIdxW = $clog2(GradeW);

  // Default number of values the store holds.
  localparam int unsigned DefCapacity = 256;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StTrunc = 2'd2;

endpackage

// ===== src/mols_ram.sv =====
module mols_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/median_of_loaded_set.sv =====
// Channel  | Direction | Handshake              | Beat contents
// ---------+-----------+------------------------+-------------------------------
// in       | input     | in_valid_i / in_ready_o | grade_i, has_grade_i, last_i
// out      | output    | out_valid_o / out_ready_i | median_o, status_o
//
// Loading accepts one beat per cycle: each value is written straight into the store
// while the store has room. A beat marked last starts the selection, which runs
// sixteen passes over the store, one per grade bit; each pass reads the stored
// values one at a time through the single read port of the store. An empty set
// skips the selection. The input is not ready during selection, nor while a finished
// result waits for the output register. Reset clears the fill count, the overflow
// flag and the output valid; the store itself is not cleared. A stalled output holds
// its result while loading goes on.

module median_of_loaded_set #(
  parameter int unsigned Capacity = mols_pkg::DefCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mols_pkg::GradeW-1:0]  grade_i,
  input  logic                         has_grade_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mols_pkg::MedianW-1:0] median_o,
  output logic [mols_pkg::StatusW-1:0] status_o
);

  // Count width holds Capacity itself; address width indexes the store.
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned GW    = mols_pkg::GradeW;
  localparam int unsigned BW    = mols_pkg::BitIdxW;

  typedef enum logic [2:0] {
    S_LOAD   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Loading state.
  logic [CntW-1:0] fill_q, fill_d;
  logic            ovf_q, ovf_d;

  // Selection state. Two order statistics are tracked in the same passes: the
  // lower and upper middle. For an odd count they coincide, so their sum is
  // twice the middle value, which is exactly the median with one more
  // fractional bit.
  logic [CntW-1:0] n_q, n_d;
  logic            empty_q, empty_d;
  logic            trunc_q, trunc_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic            rd_vld_q, rd_vld_d;
  logic [BW-1:0]   bit_q, bit_d;
  logic [GW-1:0]   pfx_lo_q, pfx_lo_d, pfx_hi_q, pfx_hi_d;
  logic [CntW-1:0] k_lo_q, k_lo_d, k_hi_q, k_hi_d;
  logic [CntW-1:0] cnt_lo_q, cnt_lo_d, cnt_hi_q, cnt_hi_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [mols_pkg::MedianW-1:0] median_q, median_d;
  logic [mols_pkg::StatusW-1:0] status_q, status_d;

  logic            in_acc;
  logic            full;
  logic            wr_en;
  logic [CntW-1:0] fill_next;
  logic [GW-1:0]   rdata;
  logic [GW-1:0]   hi_mask;
  logic            match_lo, match_hi;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (fill_q == CntW'(Capacity));
  assign wr_en      = in_acc && has_grade_i && !full;
  assign fill_next  = wr_en ? fill_q + CntW'(1) : fill_q;

  mols_ram #(
    .Width(GW),
    .Depth(Capacity)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(fill_q[AddrW-1:0]),
    .wdata_i(grade_i),
    .raddr_i(addr_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  // A value counts towards an order statistic in this pass when it agrees with
  // the prefix found so far on every bit above the current one and has a zero
  // in the current bit.
  assign hi_mask  = (~GW'(0) << bit_q) << 1;
  assign match_lo = (((rdata ^ pfx_lo_q) & hi_mask) == '0) && !rdata[bit_q];
  assign match_hi = (((rdata ^ pfx_hi_q) & hi_mask) == '0) && !rdata[bit_q];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    empty_d     = empty_q;
    trunc_d     = trunc_q;
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    bit_d       = bit_q;
    pfx_lo_d    = pfx_lo_q;
    pfx_hi_d    = pfx_hi_q;
    k_lo_d      = k_lo_q;
    k_hi_d      = k_hi_q;
    cnt_lo_d    = cnt_lo_q;
    cnt_hi_d    = cnt_hi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    median_d    = median_q;
    status_d    = status_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          fill_d = fill_next;
          ovf_d  = ovf_q || (has_grade_i && full);
          if (last_i) begin
            n_d      = fill_next;
            empty_d  = (fill_next == '0);
            trunc_d  = ovf_q || (has_grade_i && full);
            addr_d   = '0;
            bit_d    = BW'(GW - 1);
            pfx_lo_d = '0;
            pfx_hi_d = '0;
            k_lo_d   = (fill_next - CntW'(1)) >> 1;
            k_hi_d   = fill_next >> 1;
            cnt_lo_d = '0;
            cnt_hi_d = '0;
            fill_d   = '0;
            ovf_d    = 1'b0;
            state_d  = (fill_next == '0) ? S_FINISH : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (addr_q != n_q) begin
          addr_d   = addr_q + CntW'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          cnt_lo_d = cnt_lo_q + CntW'(match_lo);
          cnt_hi_d = cnt_hi_q + CntW'(match_hi);
        end else if (addr_q == n_q) begin
          // Pass complete: settle the current bit of both prefixes.
          if (k_lo_q >= cnt_lo_q) begin
            pfx_lo_d[bit_q] = 1'b1;
            k_lo_d          = k_lo_q - cnt_lo_q;
          end
          if (k_hi_q >= cnt_hi_q) begin
            pfx_hi_d[bit_q] = 1'b1;
            k_hi_d          = k_hi_q - cnt_hi_q;
          end
          cnt_lo_d = '0;
          cnt_hi_d = '0;
          addr_d   = '0;
          if (bit_q == '0) begin
            state_d = S_FINISH;
          end else begin
            bit_d = bit_q - BW'(1);
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (empty_q) begin
            median_d = '0;
            status_d = mols_pkg::StEmpty;
          end else begin
            median_d = {1'b0, pfx_lo_q} + {1'b0, pfx_hi_q};
            status_d = trunc_q ? mols_pkg::StTrunc : mols_pkg::StOk;
          end
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    empty_q  <= empty_d;
    trunc_q  <= trunc_d;
    addr_q   <= addr_d;
    bit_q    <= bit_d;
    pfx_lo_q <= pfx_lo_d;
    pfx_hi_q <= pfx_hi_d;
    k_lo_q   <= k_lo_d;
    k_hi_q   <= k_hi_d;
    cnt_lo_q <= cnt_lo_d;
    cnt_hi_q <= cnt_hi_d;
    median_q <= median_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;
  assign status_o    = status_q;

endmodule

// ===== src/mols_checker.sv =====
module mols_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         last_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [mols_pkg::MedianW-1:0] median_o,
  input logic [mols_pkg::StatusW-1:0] status_o
);

  // A stalled result beat holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_o) && $stable(status_o))
    else $error("output beat changed while stalled");

  // The last beat of a set closes the input until its result is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o)
    else $error("input ready directly after a last beat");

  // An empty set reports a zero median.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mols_pkg::StEmpty) |-> (median_o == '0))
    else $error("empty set with non-zero median");

  // Only the three defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mols_pkg::StOk) || (status_o == mols_pkg::StEmpty) ||
                    (status_o == mols_pkg::StTrunc))
    else $error("undefined status code");

endmodule

bind median_of_loaded_set mols_checker u_mols_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .last_i     (last_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .median_o   (median_o),
  .status_o   (status_o)
);
